// File: rtl/core/atsu_pkg.sv
// ----------------------------------------------------------------------------
// atsu_pkg: shared types and constants of the adaptive time smoother
// Widths, op codes, sequencer states and speed saturation helper.
// ----------------------------------------------------------------------------
package atsu_pkg;

  localparam int unsigned TimeW      = 64;
  localparam int unsigned OutTimeW   = 63;
  localparam int unsigned SpeedW     = 26;
  localparam int unsigned TlW        = 16;
  localparam int unsigned CntW       = 6;
  localparam int unsigned TpsW       = 32;
  localparam int unsigned MulAW      = 32;
  localparam int unsigned MulBW      = 26;
  localparam int unsigned MulPW      = MulAW + MulBW;
  localparam int unsigned DivNW      = 64;
  localparam int unsigned DivDW      = 32;
  localparam int unsigned SpeedFracBitsDef = 16;

  localparam logic [TpsW-1:0]   TpsReset = 32'd1000000;
  localparam logic [MulAW-1:0]  DecayQ16 = 32'd62259;
  localparam int unsigned       DecayShift = 16;
  localparam logic [CntW-1:0]   SpikeAdd = 6'd5;
  localparam logic [CntW:0]     SpikeMax = 7'd50;
  localparam logic [CntW-1:0]   SpikeMin = 6'd15;
  localparam logic signed [TlW-1:0] SpikeLim = -16'sd50;

  localparam logic [63:0] SpeedMax = 64'h3FF_FFFF;

  typedef enum logic [1:0] {
    OP_QUERY  = 2'd0,
    OP_UPDATE = 2'd1,
    OP_INIT   = 2'd2,
    OP_SPEED  = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_DECAY,
    ST_DECAY_WB,
    ST_PREP,
    ST_DIV1,
    ST_FRAC1,
    ST_MULR,
    ST_DIV2S,
    ST_DIV2,
    ST_FRAC2,
    ST_MULHI,
    ST_MULLO,
    ST_SUM,
    ST_FIN
  } state_e;

  function automatic logic [SpeedW-1:0] sat_speed(input logic [63:0] v);
    logic [63:0] s;
    s = (v > SpeedMax) ? SpeedMax : v;
    return s[SpeedW-1:0];
  endfunction

endpackage

// File: rtl/core/adaptive_time_smoother_unit.sv
// ----------------------------------------------------------------------------
// adaptive_time_smoother_unit: smoothed clock slewing toward a target time
// Sequencer around one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one op per item (tuser = op: query, update, init, set
//   speed) with now, target, time_left, direction and speed_value in tdata.
//   m_axis returns exactly one item per input: smoothed time in tdata and
//   the spike-ignored flag in tuser.
//   cfg_we_i/cfg_wdata_i write ticks_per_second; write it only while idle.
// Sequencing:
//   One item at a time; s_axis_tready is high only while the sequencer idles.
//   A smoothed-time evaluation runs two 64-step divisions on the bit-serial
//   divider plus the multiplier passes, and most of it is spent in the divider.
//   A negative elapsed time skips both divisions, a saturated first fraction
//   skips the second; init goes straight to the last sequencer step.
// Reset:
//   Times and spike count clear, both speeds load 0.3, ticks_per_second
//   loads 1000000; no clearing pass.
// Stall:
//   The result waits in the output register; a finished item holds in the
//   last sequencer step until the output register frees up.
// ----------------------------------------------------------------------------
module adaptive_time_smoother_unit #(
  parameter int unsigned SPEED_FRAC_BITS = atsu_pkg::SpeedFracBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: now[62:0], target[125:63], time_left[141:126], direction[142],
  //        speed_value[168:143], zero fill[175:169]
  input  logic [175:0] s_axis_tdata,
  // tuser: op[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: smoothed_time[62:0], zero fill[63]
  output logic [63:0]  m_axis_tdata,
  // tuser: spike_ignored[0]
  output logic         m_axis_tuser
);

  localparam int unsigned TimeW  = atsu_pkg::TimeW;
  localparam int unsigned SpeedW = atsu_pkg::SpeedW;
  localparam int unsigned FracW  = SPEED_FRAC_BITS + 1;
  localparam logic [63:0] OneQ   = 64'd1 << SPEED_FRAC_BITS;
  localparam logic [SpeedW-1:0] SpeedInit = atsu_pkg::sat_speed((64'd3 * OneQ + 64'd5) / 64'd10);
  localparam logic [SpeedW-1:0] Speed30   = atsu_pkg::sat_speed(64'd30 * OneQ);
  localparam logic [SpeedW-1:0] Floor2    = atsu_pkg::sat_speed(64'd2 * OneQ);
  localparam logic [FracW-1:0]  FracOne   = FracW'(OneQ);

  // architectural state
  atsu_pkg::state_e state_q, state_d;
  logic [31:0]        tps_q;
  logic [TimeW-1:0]   snap_q, snap_d, cur_q, cur_d, tgt_q, tgt_d;
  logic [SpeedW-1:0]  spd_q [2];
  logic [SpeedW-1:0]  spd_d [2];
  logic [atsu_pkg::CntW-1:0] cnt_q, cnt_d;

  // captured item
  atsu_pkg::op_e      op_q, op_d;
  logic [62:0]        in_now_q, in_now_d, in_tgt_q, in_tgt_d;
  logic signed [15:0] tl_q, tl_d;
  logic               dir_q, dir_d;
  logic               ign_q, ign_d;

  // working registers
  logic [TimeW-1:0]   elapsed_q, elapsed_d, mag_q, mag_d, scaled_q, scaled_d;
  logic               gneg_q, gneg_d;
  logic [SpeedW-1:0]  wspd_q, wspd_d;
  logic [31:0]        dvs_q, dvs_d;
  logic [atsu_pkg::MulPW-1:0] prod1_q, prod1_d, phi_q, phi_d;
  logic [FracW-1:0]   frac_q, frac_d;

  // output register
  logic               m_valid_q, m_valid_d;
  logic [62:0]        m_data_q, m_data_d;
  logic               m_user_q, m_user_d;

  // shared units
  logic                       div_start;
  logic [atsu_pkg::DivNW-1:0] div_n;
  logic                       div_done;
  logic [atsu_pkg::DivNW-1:0] div_quot;
  logic [atsu_pkg::DivDW-1:0] div_rem;
  logic [atsu_pkg::MulAW-1:0] mul_a;
  logic [atsu_pkg::MulBW-1:0] mul_b;
  logic [atsu_pkg::MulPW-1:0] mul_p;

  // the divider latches its divisor on start, so hand it the next value
  atsu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .divisor_i  (dvs_d),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  atsu_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  logic                s_acc;
  logic [TimeW-1:0]    gap, sm_res, sum1;
  logic                up;
  logic [atsu_pkg::CntW:0] cnt_add, cnt_sat;
  logic                spike, late;

  assign s_acc = s_axis_tvalid && s_axis_tready;
  assign gap   = tgt_q - cur_q;
  assign up    = !gap[TimeW-1] && (gap != '0);
  assign sum1  = TimeW'(prod1_q) + div_quot;
  assign sm_res = cur_q + elapsed_q + (gneg_q ? (TimeW'(0) - scaled_q) : scaled_q);

  assign late    = tl_q < 0;
  assign spike   = tl_q < atsu_pkg::SpikeLim;
  assign cnt_add = {1'b0, cnt_q} + {1'b0, atsu_pkg::SpikeAdd};
  assign cnt_sat = (cnt_add > atsu_pkg::SpikeMax) ? atsu_pkg::SpikeMax : cnt_add;

  always_comb begin
    state_d   = state_q;
    snap_d    = snap_q;
    cur_d     = cur_q;
    tgt_d     = tgt_q;
    spd_d     = spd_q;
    cnt_d     = cnt_q;
    op_d      = op_q;
    in_now_d  = in_now_q;
    in_tgt_d  = in_tgt_q;
    tl_d      = tl_q;
    dir_d     = dir_q;
    ign_d     = ign_q;
    elapsed_d = elapsed_q;
    mag_d     = mag_q;
    scaled_d  = scaled_q;
    gneg_d    = gneg_q;
    wspd_d    = wspd_q;
    dvs_d     = dvs_q;
    prod1_d   = prod1_q;
    phi_d     = phi_q;
    frac_d    = frac_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    m_valid_d = (m_axis_tready) ? 1'b0 : m_valid_q;
    div_start = 1'b0;
    div_n     = elapsed_q;
    mul_a     = '0;
    mul_b     = '0;
    s_axis_tready = (state_q == atsu_pkg::ST_IDLE);

    unique case (state_q)
      atsu_pkg::ST_IDLE: begin
        // ready is high throughout idle, so valid alone accepts
        if (s_axis_tvalid) begin
          op_d     = atsu_pkg::op_e'(s_axis_tuser);
          in_now_d = s_axis_tdata[62:0];
          in_tgt_d = s_axis_tdata[125:63];
          tl_d     = s_axis_tdata[141:126];
          dir_d    = s_axis_tdata[142];
          ign_d    = 1'b0;
          unique case (atsu_pkg::op_e'(s_axis_tuser))
            atsu_pkg::OP_QUERY:  state_d = atsu_pkg::ST_PREP;
            atsu_pkg::OP_UPDATE: state_d = atsu_pkg::ST_UPD;
            atsu_pkg::OP_INIT:   state_d = atsu_pkg::ST_FIN;
            atsu_pkg::OP_SPEED: begin
              spd_d[s_axis_tdata[142]] = s_axis_tdata[168:143];
              state_d = atsu_pkg::ST_PREP;
            end
            default: state_d = atsu_pkg::ST_IDLE;
          endcase
        end
      end
      atsu_pkg::ST_UPD: begin
        state_d = atsu_pkg::ST_PREP;
        if (late) begin
          if (spike) cnt_d = cnt_sat[atsu_pkg::CntW-1:0];
          if (spike && (cnt_sat[atsu_pkg::CntW-1:0] < atsu_pkg::SpikeMin)) begin
            ign_d = 1'b1;
          end else if (spd_q[dir_q] < Speed30) begin
            spd_d[dir_q] = atsu_pkg::sat_speed({37'd0, spd_q[dir_q], 1'b0});
          end
        end else begin
          if (cnt_q != '0) cnt_d = cnt_q - atsu_pkg::CntW'(1);
          state_d = atsu_pkg::ST_DECAY;
        end
      end
      atsu_pkg::ST_DECAY: begin
        mul_a   = atsu_pkg::DecayQ16;
        mul_b   = spd_q[dir_q];
        state_d = atsu_pkg::ST_DECAY_WB;
      end
      atsu_pkg::ST_DECAY_WB: begin
        // drop the Q0.16 fraction, floor at 2.0
        spd_d[dir_q] = (mul_p[atsu_pkg::DecayShift +: SpeedW] < Floor2) ?
                       Floor2 : mul_p[atsu_pkg::DecayShift +: SpeedW];
        state_d = atsu_pkg::ST_PREP;
      end
      atsu_pkg::ST_PREP: begin
        elapsed_d = {1'b0, in_now_q} - snap_q;
        gneg_d    = gap[TimeW-1];
        mag_d     = gap[TimeW-1] ? (TimeW'(0) - gap) : gap;
        wspd_d    = spd_q[up];
        dvs_d     = (tps_q == '0) ? 32'd1 : tps_q;
        div_n     = {1'b0, in_now_q} - snap_q;
        if (div_n[TimeW-1]) begin
          frac_d  = '0;
          state_d = atsu_pkg::ST_MULHI;
        end else begin
          state_d = atsu_pkg::ST_DIV1;
        end
      end
      atsu_pkg::ST_DIV1: begin
        // wait for elapsed / ticks_per_second
        if (div_done) state_d = atsu_pkg::ST_FRAC1;
      end
      atsu_pkg::ST_FRAC1: begin
        if ((wspd_q != '0) && (div_quot > OneQ)) begin
          frac_d  = FracOne;
          state_d = atsu_pkg::ST_MULHI;
        end else begin
          mul_a   = div_quot[atsu_pkg::MulAW-1:0];
          mul_b   = wspd_q;
          state_d = atsu_pkg::ST_MULR;
        end
      end
      atsu_pkg::ST_MULR: begin
        prod1_d = mul_p;
        mul_a   = div_rem;
        mul_b   = wspd_q;
        state_d = atsu_pkg::ST_DIV2S;
      end
      atsu_pkg::ST_DIV2S: begin
        div_start = 1'b1;
        div_n     = TimeW'(mul_p);
        state_d   = atsu_pkg::ST_DIV2;
      end
      atsu_pkg::ST_DIV2: begin
        if (div_done) state_d = atsu_pkg::ST_FRAC2;
      end
      atsu_pkg::ST_FRAC2: begin
        frac_d  = (sum1 > OneQ) ? FracOne : sum1[FracW-1:0];
        state_d = atsu_pkg::ST_MULHI;
      end
      atsu_pkg::ST_MULHI: begin
        mul_a   = mag_q[63:32];
        mul_b   = atsu_pkg::MulBW'(frac_q);
        state_d = atsu_pkg::ST_MULLO;
      end
      atsu_pkg::ST_MULLO: begin
        phi_d   = mul_p;
        mul_a   = mag_q[31:0];
        mul_b   = atsu_pkg::MulBW'(frac_q);
        state_d = atsu_pkg::ST_SUM;
      end
      atsu_pkg::ST_SUM: begin
        scaled_d = (TimeW'(phi_q) << (32 - SPEED_FRAC_BITS))
                 + (TimeW'(mul_p) >> SPEED_FRAC_BITS);
        state_d  = atsu_pkg::ST_FIN;
      end
      atsu_pkg::ST_FIN: begin
        // hold until the output register can take the item
        if (!m_valid_q || m_axis_tready) begin
          m_valid_d = 1'b1;
          m_user_d  = ign_q;
          state_d   = atsu_pkg::ST_IDLE;
          if (op_q == atsu_pkg::OP_INIT) begin
            snap_d   = {1'b0, in_now_q};
            cur_d    = {1'b0, in_tgt_q};
            tgt_d    = {1'b0, in_tgt_q};
            spd_d[0] = SpeedInit;
            spd_d[1] = SpeedInit;
            m_data_d = in_tgt_q;
          end else begin
            m_data_d = sm_res[62:0];
            if ((op_q == atsu_pkg::OP_UPDATE) && !ign_q) begin
              cur_d  = sm_res;
              snap_d = {1'b0, in_now_q};
              tgt_d  = {1'b0, in_tgt_q};
            end
          end
        end
      end
      default: state_d = atsu_pkg::ST_IDLE;
    endcase

    // first division launches on entry to ST_DIV1
    if ((state_q == atsu_pkg::ST_PREP) && (state_d == atsu_pkg::ST_DIV1)) begin
      div_start = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= atsu_pkg::ST_IDLE;
      tps_q     <= atsu_pkg::TpsReset;
      snap_q    <= '0;
      cur_q     <= '0;
      tgt_q     <= '0;
      spd_q[0]  <= SpeedInit;
      spd_q[1]  <= SpeedInit;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_we_i) tps_q <= cfg_wdata_i;
      snap_q    <= snap_d;
      cur_q     <= cur_d;
      tgt_q     <= tgt_d;
      spd_q     <= spd_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    in_now_q  <= in_now_d;
    in_tgt_q  <= in_tgt_d;
    tl_q      <= tl_d;
    dir_q     <= dir_d;
    ign_q     <= ign_d;
    elapsed_q <= elapsed_d;
    mag_q     <= mag_d;
    scaled_q  <= scaled_d;
    gneg_q    <= gneg_d;
    wspd_q    <= wspd_d;
    dvs_q     <= dvs_d;
    prod1_q   <= prod1_d;
    phi_q     <= phi_d;
    frac_q    <= frac_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q};
  assign m_axis_tuser  = m_user_q;

  a_cnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cnt_q} <= atsu_pkg::SpikeMax)
    else $error("spike count above saturation");

  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == atsu_pkg::ST_DIV1 || state_q == atsu_pkg::ST_DIV2))
    else $error("divider finished outside a division step");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q != atsu_pkg::ST_IDLE))
    else $error("sequencer idle right after accepting an item");

  a_frac_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == atsu_pkg::ST_MULHI) |-> ({{(64-FracW){1'b0}}, frac_q} <= OneQ))
    else $error("fraction above one");

endmodule

// File: rtl/core/atsu_div.sv
// ----------------------------------------------------------------------------
// atsu_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; 64-bit dividend, 32-bit divisor.
// ----------------------------------------------------------------------------
module atsu_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [atsu_pkg::DivNW-1:0]  dividend_i,
  input  logic [atsu_pkg::DivDW-1:0]  divisor_i,
  output logic                        done_o,
  output logic [atsu_pkg::DivNW-1:0]  quot_o,
  output logic [atsu_pkg::DivDW-1:0]  rem_o
);

  localparam int unsigned StepW = $clog2(atsu_pkg::DivNW);
  localparam logic [StepW-1:0] LastStep = StepW'(atsu_pkg::DivNW - 1);

  logic [atsu_pkg::DivNW-1:0] quo_q, quo_d;
  logic [atsu_pkg::DivDW-1:0] rem_q, rem_d;
  logic [atsu_pkg::DivDW-1:0] dvs_q, dvs_d;
  logic [StepW-1:0]           cnt_q, cnt_d;
  logic                       busy_q, busy_d;
  logic                       done_q, done_d;

  logic [atsu_pkg::DivDW:0]   shifted;
  logic [atsu_pkg::DivDW+1:0] diff;
  logic                       ge;

  assign shifted = {rem_q, quo_q[atsu_pkg::DivNW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_q};
  assign ge      = ~diff[atsu_pkg::DivDW+1];

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift in one dividend bit, subtract when it fits
      rem_d = ge ? diff[atsu_pkg::DivDW-1:0] : shifted[atsu_pkg::DivDW-1:0];
      quo_d = {quo_q[atsu_pkg::DivNW-2:0], ge};
      cnt_d = cnt_q + StepW'(1);
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/core/atsu_mul.sv
// ----------------------------------------------------------------------------
// atsu_mul: shared registered multiplier
// 32 x 26 unsigned product, registered: available in the cycle after the operands.
// ----------------------------------------------------------------------------
module atsu_mul (
  input  logic                        clk_i,
  input  logic [atsu_pkg::MulAW-1:0]  a_i,
  input  logic [atsu_pkg::MulBW-1:0]  b_i,
  output logic [atsu_pkg::MulPW-1:0]  p_o
);

  logic [atsu_pkg::MulPW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= atsu_pkg::MulPW'(a_i) * atsu_pkg::MulPW'(b_i);
  end

  assign p_o = p_q;

endmodule

// File: verif/atsu_checker.sv
// ----------------------------------------------------------------------------
// atsu_checker: predictor and scoreboard for the adaptive time smoother
// Watches the config port and both stream channels, predicts the smoothed
// time and spike flag for each accepted item, and compares the results in
// order.
// ----------------------------------------------------------------------------
module atsu_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [175:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [63:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           err_count_o,
  output int           pending_o,
  output int           ignored_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] OneQ    = 64'd1 << atsu_pkg::SpeedFracBitsDef;
  localparam logic [63:0] SpdInit = (64'd3 * OneQ + 64'd5) / 64'd10;
  localparam logic [63:0] Floor2  = 64'd2 * OneQ;
  localparam logic [63:0] Lim30   = 64'd30 * OneQ;

  typedef struct packed {
    logic [62:0] smoothed;
    logic        ignored;
  } result_t;

  logic [31:0] tps;
  logic [63:0] snap, cur, tgt;
  logic [63:0] spd [2];
  int unsigned spikes;
  result_t     result_q [$];

  function automatic logic [63:0] smoothed_at(input logic [63:0] t);
    logic [63:0] el, gap, sp, dv, q, r, frac, mag, scaled;
    el = t - snap;
    gap = tgt - cur;
    sp = (!gap[63] && gap != 0) ? spd[1] : spd[0];
    dv = (tps == 0) ? 64'd1 : {32'd0, tps};
    frac = 0;
    if (!el[63]) begin
      q = el / dv;
      r = el % dv;
      if (sp != 0 && q > OneQ) frac = OneQ;
      else begin
        frac = q * sp + (r * sp) / dv;
        if (frac > OneQ) frac = OneQ;
      end
    end
    mag = gap[63] ? (64'd0 - gap) : gap;
    scaled = (({32'd0, mag[63:32]} * frac) << (32 - atsu_pkg::SpeedFracBitsDef))
           + (({32'd0, mag[31:0]} * frac) >> atsu_pkg::SpeedFracBitsDef);
    if (gap[63]) scaled = 64'd0 - scaled;
    return cur + el + scaled;
  endfunction

  function automatic result_t predict_item(input logic [1:0] op_raw,
                                           input logic [175:0] d);
    atsu_pkg::op_e           op;
    logic [63:0]             t_now, t_tgt, res;
    logic signed [15:0]      tl;
    logic                    dir, ign, apply, spike;
    result_t                 o;
    op = atsu_pkg::op_e'(op_raw);
    t_now = {1'b0, d[62:0]};
    t_tgt = {1'b0, d[125:63]};
    tl = d[141:126];
    dir = d[142];
    ign = 1'b0;
    res = 0;
    case (op)
      atsu_pkg::OP_QUERY: res = smoothed_at(t_now);
      atsu_pkg::OP_UPDATE: begin
        apply = 1'b1;
        if (tl < 0) begin
          spike = tl < atsu_pkg::SpikeLim;
          if (spike) begin
            spikes += 5;
            if (spikes > 50) spikes = 50;
          end
          if (spike && spikes < 15) apply = 1'b0;
          else if (spd[dir] < Lim30) begin
            spd[dir] = spd[dir] * 2;
            if (spd[dir] > atsu_pkg::SpeedMax) spd[dir] = atsu_pkg::SpeedMax;
          end
        end else begin
          if (spikes != 0) spikes--;
          spd[dir] = (spd[dir] * {32'd0, atsu_pkg::DecayQ16}) >> atsu_pkg::DecayShift;
          if (spd[dir] < Floor2) spd[dir] = Floor2;
        end
        if (apply) begin
          cur = smoothed_at(t_now);
          snap = t_now;
          tgt = t_tgt;
          res = cur;
        end else begin
          res = smoothed_at(t_now);
          ign = 1'b1;
        end
      end
      atsu_pkg::OP_INIT: begin
        snap = t_now;
        cur = t_tgt;
        tgt = t_tgt;
        spd[0] = SpdInit;
        spd[1] = SpdInit;
        res = cur;
      end
      default: begin
        spd[dir] = {38'd0, d[168:143]};
        res = smoothed_at(t_now);
      end
    endcase
    o.smoothed = res[62:0];
    o.ignored = ign;
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got, want;
    int      errs;
    if (!rst_ni) begin
      tps = atsu_pkg::TpsReset;
      snap = 0;
      cur = 0;
      tgt = 0;
      spd[0] = SpdInit;
      spd[1] = SpdInit;
      spikes = 0;
      result_q.delete();
      err_count_o <= 0;
      pending_o <= 0;
      ignored_count_o <= 0;
    end else begin
      errs = 0;
      if (cfg_we_i) tps = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready)
        result_q.push_back(predict_item(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.smoothed = m_axis_tdata[62:0];
        got.ignored = m_axis_tuser;
        if (result_q.size() == 0) begin
          $error("result with no item outstanding: smoothed_time %0d", got.smoothed);
          errs++;
        end else begin
          want = result_q.pop_front();
          if (got.smoothed !== want.smoothed) begin
            $error("smoothed_time expected %0d actual %0d", want.smoothed, got.smoothed);
            errs++;
          end
          if (got.ignored !== want.ignored) begin
            $error("spike_ignored expected %0b actual %0b", want.ignored, got.ignored);
            errs++;
          end
          if (want.ignored) ignored_count_o <= ignored_count_o + 1;
        end
      end
      if (errs != 0) err_count_o <= err_count_o + errs;
      pending_o <= result_q.size();
    end
  end

endmodule

// File: verif/tb_adaptive_time_smoother_unit.sv
// ----------------------------------------------------------------------------
// tb_adaptive_time_smoother_unit: stimulus and verdict for the time smoother
// Directed corner items, then random phases over several ticks_per_second
// settings with random idling on both stream sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_adaptive_time_smoother_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ItemsPerPhase = 300;
  localparam longint CycleLimit = 3000000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         cfg_we_i = 1'b0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tuser;
  int           err_count, pending, ignored_count;
  bit           quiet, hold_req;
  longint       cycles = 0;
  int           op_count [4];
  logic [62:0]  base;

  always #5 clk_i = ~clk_i;

  adaptive_time_smoother_unit DUT (.*);

  atsu_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .err_count_o(err_count), .pending_o(pending), .ignored_count_o(ignored_count)
  );

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // output side: random stalls, plus one long hold-off on request
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        g = pick_gap();
        if (g == 0) m_axis_tready <= 1'b1;
        else begin
          m_axis_tready <= 1'b0;
          repeat (g - 1) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_item(input atsu_pkg::op_e op, input logic [62:0] t_now,
                           input logic [62:0] t_tgt, input logic [15:0] tl,
                           input logic dir, input logic [25:0] sv);
    int g;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, sv, dir, tl, t_tgt, t_now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    op_count[op]++;
    g = pick_gap();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // lower valid and wait until all results are back before touching the register
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_tps(input logic [31:0] v);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [62:0] rand63();
    return 63'({$urandom(), $urandom()});
  endfunction

  function automatic logic [62:0] near(input logic [62:0] t);
    logic [62:0] off;
    off = 63'($urandom_range(0, 200000));
    return ($urandom_range(0, 1) != 0) ? t + off : t - off;
  endfunction

  task automatic random_item();
    int            r;
    atsu_pkg::op_e op;
    logic [62:0]   t_now, t_tgt;
    logic [15:0]   tl;
    logic [25:0]   sv;
    r = $urandom_range(0, 99);
    op = (r < 35) ? atsu_pkg::OP_QUERY : (r < 75) ? atsu_pkg::OP_UPDATE :
         (r < 88) ? atsu_pkg::OP_SPEED : atsu_pkg::OP_INIT;
    base = base + 63'($urandom_range(0, 300000));
    t_now = ($urandom_range(0, 19) == 0) ? rand63() : base;
    t_tgt = ($urandom_range(0, 19) == 0) ? rand63() : near(base);
    r = $urandom_range(0, 9);
    case (r)
      0: tl = 16'($urandom());
      1: tl = -16'sd51;
      2: tl = -16'sd50;
      3: tl = 16'd0;
      4, 5: tl = 16'(-$urandom_range(51, 500));
      6: tl = 16'(-$urandom_range(1, 50));
      default: tl = 16'($urandom_range(0, 300));
    endcase
    r = $urandom_range(0, 9);
    sv = (r == 0) ? 26'h3FFFFFF : (r == 1) ? 26'd0 : (r < 5) ? 26'($urandom()) :
         26'($urandom_range(0, 30 << 16));
    send_item(op, t_now, t_tgt, tl, 1'($urandom_range(0, 1)), sv);
  endtask

  initial begin
    logic [31:0] tps_set [6];
    tps_set = '{32'd1000, 32'd1, 32'hFFFFFFFF, 32'd0, 32'd1000000, 32'd37};
    base = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: reset state, field extremes, spike filter and speed rules
    quiet = 1'b1;
    send_item(atsu_pkg::OP_QUERY, 63'd0, 63'd0, 16'd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_QUERY, '1, '1, 16'h8000, 1'b1, '1);
    send_item(atsu_pkg::OP_INIT, 63'd1000, 63'd5000, 16'd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_QUERY, 63'd500, 63'd0, 16'd0, 1'b0, 26'd0);   // now before snapshot
    send_item(atsu_pkg::OP_QUERY, 63'd300000, 63'd0, 16'd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd400000, 63'd900000, -16'sd51, 1'b1, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd410000, 63'd900000, -16'sd51, 1'b1, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd420000, 63'd900000, -16'sd51, 1'b1, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd430000, 63'd100, -16'sd50, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd440000, 63'd100, -16'sd1, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd450000, 63'd100, 16'sd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd460000, 63'd600000, 16'sd32767, 1'b1, 26'd0);
    send_item(atsu_pkg::OP_UPDATE, 63'd470000, 63'd600000, -16'sd32768, 1'b1, 26'd0);
    send_item(atsu_pkg::OP_SPEED, 63'd480000, 63'd0, 16'd0, 1'b1, 26'h3FFFFFF);
    send_item(atsu_pkg::OP_UPDATE, 63'd490000, 63'd990000, -16'sd10, 1'b1, 26'd0);
    send_item(atsu_pkg::OP_SPEED, 63'd500000, 63'd0, 16'd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_QUERY, 63'd9000000, 63'd0, 16'd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_SPEED, 63'd510000, 63'd0, 16'd0, 1'b1, 26'd0);
    send_item(atsu_pkg::OP_QUERY, 63'd520000, 63'd0, 16'd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_INIT, '1, '1, 16'd0, 1'b0, 26'd0);
    send_item(atsu_pkg::OP_QUERY, 63'd0, 63'd0, 16'd0, 1'b0, 26'd0);
    base = 63'd600000;

    foreach (tps_set[p]) begin
      write_tps(tps_set[p]);
      quiet = (p == 4);
      if (p == 1) hold_req = 1'b1;
      send_item(atsu_pkg::OP_INIT, base, near(base), 16'd0, 1'b0, 26'd0);
      repeat (ItemsPerPhase) random_item();
    end

    drain();
    repeat (200) @(posedge clk_i);
    $display("Covered %0d queries, %0d updates (%0d spikes dropped), %0d inits, %0d speed sets",
             op_count[atsu_pkg::OP_QUERY], op_count[atsu_pkg::OP_UPDATE], ignored_count,
             op_count[atsu_pkg::OP_INIT], op_count[atsu_pkg::OP_SPEED]);
    $display("over six ticks_per_second settings incl. 0, 1 and all-ones, with stalls");
    if (err_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
